// File: rtl/pslb_pkg.sv
// ----------------------------------------------------------------------------
// pslb_pkg
// Shared types and constants for the proximity status LED blinker.
// ----------------------------------------------------------------------------
`default_nettype none

package pslb_pkg;

  typedef enum logic [1:0] {
    MODE_READY_NEAR     = 2'd0,
    MODE_NOT_READY_NEAR = 2'd1,
    MODE_READY_FAR      = 2'd2,
    MODE_NOT_READY_FAR  = 2'd3
  } mode_t;

  typedef enum logic {
    ACT_TICK       = 1'b0,
    ACT_SET_RESULT = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    REG_SAMPLE_PERIOD  = 2'd0,
    REG_NEAR_THRESHOLD = 2'd1,
    REG_SLOW_THRESHOLD = 2'd2,
    REG_READY_INTENS   = 2'd3
  } reg_index_t;

  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [15:0] SamplePeriodReset = 16'd60;
  localparam logic [8:0]  NearThresholdReset = 9'd30;
  localparam logic [31:0] SlowThresholdReset = 32'd60000;
  localparam logic [7:0]  ReadyIntensityReset = 8'd50;

  localparam logic [14:0] EchoLimitUs = 15'd25000;
  localparam logic [7:0]  DutyOff = 8'd255;
  localparam logic [7:0]  DutyOn = 8'd0;
  localparam logic signed [9:0] NoDistance = -10'sd1;

  // 0.034 cm/us round trip -> echo*17/1000; the /1000 is a reciprocal multiply,
  // exact for every product below 2^29/88.
  localparam logic [4:0]  EchoScale = 5'd17;
  localparam logic [19:0] Div1000Mul = 20'd536871;
  localparam int unsigned Div1000Shift = 29;

  // On/off durations in ms of the far blink patterns.
  localparam logic [9:0] PatShortMs = 10'd100;
  localparam logic [9:0] PatReadyLongMs = 10'd700;
  localparam logic [9:0] PatNotReadyLongMs = 10'd900;

  function automatic logic [9:0] pattern_dur(input mode_t mode, input logic [1:0] step);
    logic [9:0] dur;
    if (mode == MODE_READY_FAR) begin
      dur = (step == 2'd3) ? PatReadyLongMs : PatShortMs;
    end else begin
      dur = step[0] ? PatNotReadyLongMs : PatShortMs;
    end
    return dur;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pslb_item_if.sv
// ----------------------------------------------------------------------------
// pslb_item_if
// Input channel: tick or set-result item with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pslb_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] now_ms;
  logic [14:0] echo_us;
  logic        ready_req;
  logic [31:0] duration_ms;

  modport source (output valid, action, now_ms, echo_us, ready_req, duration_ms,
                  input ready);
  modport sink (input valid, action, now_ms, echo_us, ready_req, duration_ms,
                output ready);
endinterface

`default_nettype wire

// File: rtl/pslb_result_if.sv
// ----------------------------------------------------------------------------
// pslb_result_if
// Output channel: LED duties, mode and last distance with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pslb_result_if;
  logic              valid;
  logic              ready;
  logic [7:0]        red_duty;
  logic [7:0]        green_duty;
  logic [7:0]        blue_duty;
  logic [1:0]        led_mode;
  logic signed [9:0] distance_cm;

  modport source (output valid, red_duty, green_duty, blue_duty, led_mode, distance_cm,
                  input ready);
  modport sink (input valid, red_duty, green_duty, blue_duty, led_mode, distance_cm,
                output ready);
endinterface

`default_nettype wire

// File: rtl/proximity_status_led_blinker_unit.sv
// ----------------------------------------------------------------------------
// proximity_status_led_blinker_unit
// Status LED driver: distance sampling, ready/near mode and far blink patterns.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless stalled. Each item is captured in an
// input register, goes through the update logic (wrapping sample-period check,
// distance by reciprocal multiply, mode select and blink step) and lands in a
// result register once that register is free or being read out. The
// result register and the input register each hold one item; the block keeps
// accepting while a finished result waits, and stalls only when both are full.
// Configuration writes go through wr_en/wr_index/wr_data and take effect on
// the next clock; write them only while no item is in flight.
`default_nettype none

module proximity_status_led_blinker_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  pslb_item_if.sink                                item,
  pslb_result_if.source                            result,
  input  wire logic                                wr_en,
  input  wire logic [pslb_pkg::CfgIndexWidth-1:0]  wr_index,
  input  wire logic [pslb_pkg::CfgDataWidth-1:0]   wr_data
);

  // configuration
  logic [15:0] sample_period_ms;
  logic [8:0]  near_threshold_cm;
  logic [31:0] slow_threshold_ms;
  logic [7:0]  lit_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period_ms  <= pslb_pkg::SamplePeriodReset;
      near_threshold_cm <= pslb_pkg::NearThresholdReset;
      slow_threshold_ms <= pslb_pkg::SlowThresholdReset;
      lit_duty          <= pslb_pkg::ReadyIntensityReset;
    end else if (wr_en) begin
      case (pslb_pkg::reg_index_t'(wr_index))
        pslb_pkg::REG_SAMPLE_PERIOD:  sample_period_ms  <= wr_data[15:0];
        pslb_pkg::REG_NEAR_THRESHOLD: near_threshold_cm <= wr_data[8:0];
        pslb_pkg::REG_SLOW_THRESHOLD: slow_threshold_ms <= wr_data[31:0];
        pslb_pkg::REG_READY_INTENS:   lit_duty          <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        in_valid;
  logic        in_action;
  logic [31:0] in_now_ms;
  logic [14:0] in_echo_us;
  logic        in_ready_req;
  logic [31:0] in_duration_ms;

  logic advance;
  logic in_xfer;

  assign advance    = in_valid && (!result.valid || result.ready);
  assign item.ready = !in_valid || advance;
  assign in_xfer    = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_xfer) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_action      <= item.action;
      in_now_ms      <= item.now_ms;
      in_echo_us     <= item.echo_us;
      in_ready_req   <= item.ready_req;
      in_duration_ms <= item.duration_ms;
    end
  end

  // state
  pslb_pkg::mode_t   mode, mode_next;
  logic [1:0]        pattern_step, pattern_step_next;
  logic              lamp_on, lamp_on_next;
  logic [31:0]       step_start_ms, step_start_ms_next;
  logic [31:0]       last_sample_ms, last_sample_ms_next;
  logic signed [9:0] last_distance, last_distance_next;
  logic              result_ready, result_ready_next;
  logic              result_slow, result_slow_next;

  // distance arithmetic
  logic [19:0] echo_scaled;
  logic [39:0] div_prod;
  logic [8:0]  dist_cm;
  logic        echo_ok;
  logic        sample_due;
  logic        near;
  logic [31:0] step_elapsed;
  logic        step_due;
  pslb_pkg::mode_t target;

  assign echo_scaled = 20'(in_echo_us) * 20'(pslb_pkg::EchoScale);
  assign div_prod    = 40'(echo_scaled) * 40'(pslb_pkg::Div1000Mul);
  assign dist_cm     = div_prod[pslb_pkg::Div1000Shift +: 9];
  assign echo_ok     = (in_echo_us != '0) && (in_echo_us <= pslb_pkg::EchoLimitUs);
  assign sample_due  = (in_now_ms - last_sample_ms) >= {16'd0, sample_period_ms};
  assign step_elapsed = in_now_ms - step_start_ms;
  assign step_due    = step_elapsed >= {22'd0, pslb_pkg::pattern_dur(mode, pattern_step)};

  always_comb begin
    last_sample_ms_next = last_sample_ms;
    last_distance_next  = last_distance;
    mode_next           = mode;
    pattern_step_next   = pattern_step;
    lamp_on_next        = lamp_on;
    step_start_ms_next  = step_start_ms;
    result_ready_next   = result_ready;
    result_slow_next    = result_slow;
    near                = 1'b0;
    target              = mode;

    if (pslb_pkg::action_t'(in_action) == pslb_pkg::ACT_SET_RESULT) begin
      result_ready_next = in_ready_req;
      result_slow_next  = in_ready_req && (in_duration_ms > slow_threshold_ms);
    end else begin
      if (sample_due) begin
        last_sample_ms_next = in_now_ms;
        last_distance_next  = echo_ok ? $signed({1'b0, dist_cm}) : pslb_pkg::NoDistance;
      end
      near   = !last_distance_next[9] && (last_distance_next[8:0] <= near_threshold_cm);
      target = pslb_pkg::mode_t'({!near, !result_ready});
      if (target != mode) begin
        // restarting the pattern: elapsed time is zero, so no step this tick
        mode_next          = target;
        pattern_step_next  = '0;
        lamp_on_next       = target[1];
        step_start_ms_next = in_now_ms;
      end else if (mode[1] && step_due) begin
        step_start_ms_next = in_now_ms;
        if (mode == pslb_pkg::MODE_READY_FAR) begin
          pattern_step_next = pattern_step + 2'd1;
        end else begin
          pattern_step_next = {1'b0, !pattern_step[0]};
        end
        lamp_on_next = !pattern_step_next[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= pslb_pkg::MODE_NOT_READY_NEAR;
      pattern_step   <= '0;
      lamp_on        <= 1'b0;
      step_start_ms  <= '0;
      last_sample_ms <= '0;
      last_distance  <= pslb_pkg::NoDistance;
      result_ready   <= 1'b0;
      result_slow    <= 1'b0;
    end else if (advance) begin
      mode           <= mode_next;
      pattern_step   <= pattern_step_next;
      lamp_on        <= lamp_on_next;
      step_start_ms  <= step_start_ms_next;
      last_sample_ms <= last_sample_ms_next;
      last_distance  <= last_distance_next;
      result_ready   <= result_ready_next;
      result_slow    <= result_slow_next;
    end
  end

  // displayed color from the updated state
  logic [7:0] red_next, green_next, blue_next;
  logic       show_ready, show_white;

  always_comb begin
    red_next   = pslb_pkg::DutyOff;
    green_next = pslb_pkg::DutyOff;
    blue_next  = pslb_pkg::DutyOff;
    show_ready = 1'b0;
    show_white = 1'b0;
    case (mode_next)
      pslb_pkg::MODE_READY_NEAR:     show_ready = 1'b1;
      pslb_pkg::MODE_NOT_READY_NEAR: show_ready = 1'b0;
      pslb_pkg::MODE_READY_FAR:      show_ready = lamp_on_next;
      pslb_pkg::MODE_NOT_READY_FAR:  show_white = lamp_on_next;
      default: ;
    endcase
    if (show_ready) begin
      if (result_slow_next) begin
        red_next = lit_duty;
      end else begin
        green_next = lit_duty;
      end
    end else if (show_white) begin
      red_next   = pslb_pkg::DutyOn;
      green_next = pslb_pkg::DutyOn;
      blue_next  = pslb_pkg::DutyOn;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.red_duty    <= red_next;
      result.green_duty  <= green_next;
      result.blue_duty   <= blue_next;
      result.led_mode    <= mode_next;
      result.distance_cm <= last_distance_next;
    end
  end

  // near modes never blink, so the pattern index stays at its start
  a_near_step_idle: assert property (@(posedge clk) disable iff (rst)
    !mode[1] |-> (pattern_step == 2'd0 && lamp_on == 1'b0))
    else $error("pattern running in a near mode");

  a_not_ready_far_step: assert property (@(posedge clk) disable iff (rst)
    (mode == pslb_pkg::MODE_NOT_READY_FAR) |-> (pattern_step[1] == 1'b0 &&
                                                lamp_on == !pattern_step[0]))
    else $error("not-ready far pattern out of step");

  a_not_ready_near_dark: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.led_mode == pslb_pkg::MODE_NOT_READY_NEAR) |->
      (result.red_duty == pslb_pkg::DutyOff && result.green_duty == pslb_pkg::DutyOff &&
       result.blue_duty == pslb_pkg::DutyOff))
    else $error("LED lit in not-ready near mode");

  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    !last_distance[9] |-> (last_distance[8:0] <= 9'd425))
    else $error("sampled distance beyond sensor range");

endmodule

`default_nettype wire
